// ===== design/tqtm_pkg.sv =====
// Shared types, sizes and codes for the two-queue timestamp merge.
`default_nettype none

package tqtm_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TS_W        = 32;
    localparam int HANDLE_W    = 32;
    localparam int COUNT_W     = 7;

    typedef enum logic [1:0] {
        OP_PUSH_VIDEO = 2'd0,
        OP_PUSH_AUDIO = 2'd1,
        OP_POP        = 2'd2,
        OP_CLEAR      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_VIDEO = 1'b0,
        KIND_AUDIO = 1'b1
    } t_kind;

    typedef struct packed {
        t_op                 operation;
        logic [TS_W-1:0]     frame_timestamp;
        logic [HANDLE_W-1:0] frame_handle;
    } t_request;

    typedef struct packed {
        t_status             status;
        t_kind               popped_kind;
        logic [TS_W-1:0]     popped_timestamp;
        logic [HANDLE_W-1:0] popped_handle;
        logic [COUNT_W-1:0]  video_count;
        logic [COUNT_W-1:0]  audio_count;
        logic                next_valid;
        logic [TS_W-1:0]     next_timestamp;
    } t_result;

    // One stored frame.
    typedef struct packed {
        logic [TS_W-1:0]     ts;
        logic [HANDLE_W-1:0] handle;
    } t_frame;

    // Per-queue command for the current cycle.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_q_ctrl;

    // Per-queue status: current front plus the state after this cycle's command.
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [FILL_W-1:0] fill;
        t_frame            front;
        logic [FILL_W-1:0] next_fill;
        logic              next_any;
        t_frame            next_front;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== design/tqtm_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module tqtm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/tqtm_queue.sv =====
// One frame FIFO: RAM body with the first two entries held in registers.
`default_nettype none

module tqtm_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tqtm_pkg::t_q_ctrl i_ctrl,
    input  wire tqtm_pkg::t_frame  i_frame,
    output tqtm_pkg::t_q_stat      o_stat
);

    import tqtm_pkg::*;

    localparam logic [FILL_W:0]   DEPTH_X  = (FILL_W + 1)'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    logic [IDX_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_frame            r_e0, n_e0;
    t_frame            r_e1, n_e1;
    logic              r_byp_valid, n_byp_valid;
    t_frame            r_byp;

    logic              do_push;
    logic              do_pop;
    logic              wr_en;
    logic [IDX_W-1:0]  tail_idx;
    logic [IDX_W-1:0]  rd_idx;
    t_frame            ram_rd;
    t_frame            third;

    // Index sum is always below twice the depth: one compare and subtract.
    function automatic logic [IDX_W-1:0] f_wrap(input logic [FILL_W:0] sum);
        logic [FILL_W:0] red;
        red = (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
        return IDX_W'(red);
    endfunction

    assign do_push  = i_ctrl.push && (r_fill != FILL_MAX);
    assign do_pop   = i_ctrl.pop && (r_fill != '0);
    assign wr_en    = do_push && !i_ctrl.clear;
    assign tail_idx = f_wrap((FILL_W + 1)'(r_head) + (FILL_W + 1)'(r_fill));

    // Third entry from the front: RAM output, or the write that landed on it.
    assign third = r_byp_valid ? r_byp : ram_rd;

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        n_e0   = r_e0;
        n_e1   = r_e1;
        if (i_ctrl.clear) begin
            n_head = '0;
            n_fill = '0;
        end else if (do_push) begin
            n_fill = r_fill + FILL_W'(1);
            if (r_fill == FILL_W'(0)) begin
                n_e0 = i_frame;
            end
            if (r_fill == FILL_W'(1)) begin
                n_e1 = i_frame;
            end
        end else if (do_pop) begin
            n_head = f_wrap((FILL_W + 1)'(r_head) + (FILL_W + 1)'(1));
            n_fill = r_fill - FILL_W'(1);
            n_e0   = r_e1;
            n_e1   = third;
        end
    end

    // Keep the RAM pointed at the entry two behind the next front.
    assign rd_idx      = f_wrap((FILL_W + 1)'(n_head) + (FILL_W + 1)'(2));
    assign n_byp_valid = wr_en && (tail_idx == rd_idx);

    tqtm_ram #(
        .WIDTH ($bits(t_frame)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (tail_idx),
        .i_wr_data (i_frame),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_byp_valid <= n_byp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0  <= n_e0;
        r_e1  <= n_e1;
        r_byp <= i_frame;
    end

    assign o_stat.empty      = (r_fill == '0);
    assign o_stat.full       = (r_fill == FILL_MAX);
    assign o_stat.fill       = r_fill;
    assign o_stat.front      = r_e0;
    assign o_stat.next_fill  = n_fill;
    assign o_stat.next_any   = (n_fill != '0);
    assign o_stat.next_front = n_e0;

endmodule

`default_nettype wire

// ===== design/two_queue_timestamp_merge.sv =====
// Top level of the two-queue timestamp merge: request decode, pop choice, result register.
`default_nettype none

// Two frame FIFOs, video and audio, each QUEUE_DEPTH deep, hold timestamped
// frame handles. Each request pushes one frame into a queue, pops the frame
// with the earliest front timestamp (video wins a tie or when audio is
// empty), or clears both queues. Every request yields exactly one result,
// carrying the status (ok, pop with nothing queued, push dropped because the
// queue was full), the popped frame on a successful pop (zeros otherwise),
// both queue counts after the request and the earliest front timestamp left.
// Rate: one request per clock unless stalled, with the result registered and
// valid in the cycle after acceptance. The request side stalls only while a
// result sits unclaimed in the output register and the result side is not
// ready. Each queue keeps its first two frames in flip-flops and the rest in
// a RAM whose registered read port is always aimed at the third frame, so
// back-to-back pops never wait on the memory. Entries need no clearing after
// reset; only the fill counts, pointers and bypass flag are reset.
module two_queue_timestamp_merge (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tqtm_pkg::t_request i_in_request,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tqtm_pkg::t_result       o_out_result
);

    import tqtm_pkg::*;

    logic    accept;
    t_q_ctrl v_ctrl, a_ctrl;
    t_q_stat v_stat, a_stat;
    t_frame  in_frame;
    t_result n_result;
    t_result r_out;
    logic    r_out_valid;

    // Take a request whenever the result register is free or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign in_frame.ts     = i_in_request.frame_timestamp;
    assign in_frame.handle = i_in_request.frame_handle;

    // Decode the request, pick the pop source, build the status fields.
    always_comb begin
        v_ctrl   = '0;
        a_ctrl   = '0;
        n_result = '0;
        case (i_in_request.operation)
            OP_PUSH_VIDEO: begin
                v_ctrl.push = accept;
                if (v_stat.full) begin
                    n_result.status = ST_PUSH_FULL;
                end
            end
            OP_PUSH_AUDIO: begin
                a_ctrl.push = accept;
                if (a_stat.full) begin
                    n_result.status = ST_PUSH_FULL;
                end
            end
            OP_POP: begin
                // Video goes first on a tie or when audio has nothing queued.
                if (!v_stat.empty && (a_stat.empty || v_stat.front.ts <= a_stat.front.ts)) begin
                    v_ctrl.pop                = accept;
                    n_result.popped_kind      = KIND_VIDEO;
                    n_result.popped_timestamp = v_stat.front.ts;
                    n_result.popped_handle    = v_stat.front.handle;
                end else if (!a_stat.empty) begin
                    a_ctrl.pop                = accept;
                    n_result.popped_kind      = KIND_AUDIO;
                    n_result.popped_timestamp = a_stat.front.ts;
                    n_result.popped_handle    = a_stat.front.handle;
                end else begin
                    n_result.status = ST_POP_EMPTY;
                end
            end
            OP_CLEAR: begin
                v_ctrl.clear = accept;
                a_ctrl.clear = accept;
            end
            default: begin
            end
        endcase

        // Report the state as it stands after this request.
        n_result.video_count = COUNT_W'(v_stat.next_fill);
        n_result.audio_count = COUNT_W'(a_stat.next_fill);
        n_result.next_valid  = v_stat.next_any || a_stat.next_any;
        if (v_stat.next_any && a_stat.next_any) begin
            n_result.next_timestamp = (v_stat.next_front.ts <= a_stat.next_front.ts)
                                    ? v_stat.next_front.ts : a_stat.next_front.ts;
        end else if (v_stat.next_any) begin
            n_result.next_timestamp = v_stat.next_front.ts;
        end else if (a_stat.next_any) begin
            n_result.next_timestamp = a_stat.next_front.ts;
        end
    end

    tqtm_queue u_video (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (v_ctrl),
        .i_frame (in_frame),
        .o_stat  (v_stat)
    );

    tqtm_queue u_audio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (a_ctrl),
        .i_frame (in_frame),
        .o_stat  (a_stat)
    );

    // Hold the result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    // The reported pending flag matches the queue fills it was computed from.
    a_next_valid_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out.next_valid == ((v_stat.fill != '0) || (a_stat.fill != '0))))
        else $error("next_valid disagrees with queue fills");

    // A dropped push leaves both queues untouched.
    a_drop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((r_out.status != ST_PUSH_FULL)
                    || ($stable(v_stat.fill) && $stable(a_stat.fill))))
        else $error("dropped push changed a queue");

    // A pop on empty queues can only leave nothing pending.
    a_empty_pop_nothing_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((r_out.status != ST_POP_EMPTY) || !r_out.next_valid))
        else $error("empty pop reported a pending frame");

endmodule

`default_nettype wire
